### rtl/core/ftct_pkg.sv
// Shared constants and types for the five-tuple connection table.
// No dependencies; imported by the table top level.
`default_nettype none

package ftct_pkg;

  // table geometry
  localparam int HASH_BUCKETS = 100;
  localparam int WAYS         = 4;
  localparam int SLOT_COUNT   = HASH_BUCKETS * WAYS;
  localparam int BUCKET_W     = $clog2(HASH_BUCKETS);
  localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_W       = $clog2(SLOT_COUNT);
  localparam int HANDLE_W     = 9;

  // one stored entry: {src_addr, dst_addr, src_port, dst_port, proto}
  localparam int ENTRY_W  = 104;
  // one way in a bucket row: {valid, entry}
  localparam int WAY_BITS = ENTRY_W + 1;
  localparam int ROW_W    = WAYS * WAY_BITS;

  // sum mod HASH_BUCKETS by reciprocal multiply: exact for any 32-bit sum
  localparam int          HASH_L     = $clog2(HASH_BUCKETS);
  localparam int          HASH_SHIFT = 32 + HASH_L;
  localparam logic [63:0] HASH_MAGIC =
    ((64'd1 << HASH_SHIFT) + 64'(HASH_BUCKETS) - 64'd1) / 64'(HASH_BUCKETS);
  localparam int          PROD_W     = 65;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_FULL       = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [7:0]          proto;
    logic [31:0]         src_addr;
    logic [31:0]         dst_addr;
    logic [15:0]         src_port;
    logic [15:0]         dst_port;
    logic                outbound;
    logic [HANDLE_W-1:0] del_handle;
  } req_t;

endpackage

`default_nettype wire

### rtl/core/ftct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
`default_nettype none

module ftct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/five_tuple_connection_table_top.sv
// Five-tuple connection table: hash pipeline, bucket RAM, way compare.
// Depends on ftct_pkg and ftct_ram.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | request: op, outbound in tuser; tuple,
//          |     |                    | del_handle in tdata
//  m_      | out | m_tvalid/m_tready  | result: status in tuser, handle in tdata
//
// One request is accepted per cycle unless stalled; it moves through r1 to r4
// and the result register. Rate is set by the bucket RAM: one row read and one
// row write per cycle, with the previous cycle's write forwarded into the
// compare stage. Each row keeps its ways' valid flags beside the tuples. After
// rst a clearing pass zeroes the 100 bucket rows with s_tready held low. Each
// stage holds while the next one is full, so bubbles are squeezed out; while a
// result waits, requests enter until all stages fill.
`default_nettype none

module five_tuple_connection_table_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [7:0] proto, [39:8] src_addr, [71:40] dst_addr, [87:72] src_port,
  // [103:88] dst_port, [112:104] del_handle, [119:113] zero
  input  wire logic [119:0] s_tdata,
  // [1:0] op, [2] outbound
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [8:0] handle, [15:9] zero
  output logic      [15:0]  m_tdata,
  // [1:0] status
  output logic      [1:0]   m_tuser
);

  import ftct_pkg::*;

  // pipeline occupancy and per-stage enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en_out;
  req_t r1, r2, r3, r4;

  logic [31:0]         sum2, sum3;
  logic [PROD_W-1:0]   prod3;
  logic [BUCKET_W-1:0] bucket3, addr3, addr4;

  // clearing pass over the bucket rows after reset
  logic                clr_busy;
  logic [BUCKET_W-1:0] clr_addr;

  // last row write, forwarded to the next compare
  logic                fwd_valid;
  logic [BUCKET_W-1:0] fwd_bucket;
  logic [ROW_W-1:0]    fwd_row;

  logic [ROW_W-1:0]    ram_rdata, row_cur, row_new, ram_wdata;
  logic [BUCKET_W-1:0] ram_waddr;
  logic                ram_we, ram_wr;

  assign en_out   = !m_tvalid || m_tready;
  assign en4      = !v4 || en_out;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1 && !clr_busy;

  // ---- control state
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      m_tvalid  <= 1'b0;
      fwd_valid <= 1'b0;
      clr_busy  <= 1'b1;
      clr_addr  <= '0;
    end else begin
      if (en1) v1 <= s_tvalid && s_tready;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) begin
        v4        <= v3;
        fwd_valid <= v4 && en_out && ram_we;
      end
      if (en_out) m_tvalid <= v4;
      if (clr_busy) begin
        clr_addr <= clr_addr + BUCKET_W'(1);
        if (clr_addr == BUCKET_W'(HASH_BUCKETS - 1)) clr_busy <= 1'b0;
      end
    end
  end

  // ---- payload
  always_ff @(posedge clk) begin
    if (en1) begin
      r1.op         <= op_t'(s_tuser[1:0]);
      r1.outbound   <= s_tuser[2];
      r1.proto      <= s_tdata[7:0];
      r1.src_addr   <= s_tdata[39:8];
      r1.dst_addr   <= s_tdata[71:40];
      r1.src_port   <= s_tdata[87:72];
      r1.dst_port   <= s_tdata[103:88];
      r1.del_handle <= s_tdata[112:104];
    end
    // stage 2: wrapping sum; symmetric, so the outbound swap does not matter
    if (en2) begin
      r2   <= r1;
      sum2 <= 32'(r1.proto) + r1.src_addr + r1.dst_addr
            + 32'(r1.src_port) + 32'(r1.dst_port);
    end
    // stage 3: reciprocal multiply
    if (en3) begin
      r3    <= r2;
      sum3  <= sum2;
      prod3 <= {33'd0, sum2} * {32'd0, HASH_MAGIC[32:0]};
    end
    if (en4) begin
      r4    <= r3;
      addr4 <= addr3;
    end
    if (en4) begin
      fwd_bucket <= addr4;
      fwd_row    <= row_new;
    end
  end

  // stage 3: quotient back-multiply and subtract gives the bucket
  logic [31:0] quot3, rem3;
  logic        del_in3;
  always_comb begin
    quot3   = 32'(prod3 >> HASH_SHIFT);
    rem3    = sum3 - 32'(quot3 * 32'(HASH_BUCKETS));
    bucket3 = rem3[BUCKET_W-1:0];
    // delete reads the row holding its handle; out-of-range handles read row 0
    del_in3 = 32'(r3.del_handle) < SLOT_COUNT;
    if (r3.op == OP_DELETE) begin
      addr3 = del_in3 ? BUCKET_W'(32'(r3.del_handle) / WAYS) : '0;
    end else begin
      addr3 = bucket3;
    end
  end

  // clearing pass owns the write port until it ends; no request is in flight then
  assign ram_wr    = clr_busy || ram_we;
  assign ram_waddr = clr_busy ? clr_addr : addr4;
  assign ram_wdata = clr_busy ? '0 : row_new;

  ftct_ram #(
    .WIDTH(ROW_W),
    .DEPTH(HASH_BUCKETS)
  ) u_rows (
    .clk  (clk),
    .we   (ram_wr),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (en4),
    .raddr(addr3),
    .rdata(ram_rdata)
  );

  // ---- stage 4: compare ways, pick slot, update
  logic                fire;
  logic                swap;
  logic [ENTRY_W-1:0]  key;
  logic [WAYS-1:0]     vrow, match;
  logic                hit, has_free, del_ok;
  logic [WAY_W-1:0]    hit_way, free_way, del_way;
  logic [SLOT_W-1:0]   slot_base, hit_slot, free_slot;
  status_t             status;
  logic [HANDLE_W-1:0] handle;

  assign fire = v4 && en_out;

  always_comb begin
    row_cur = (fwd_valid && fwd_bucket == addr4) ? fwd_row : ram_rdata;
    swap    = (r4.op == OP_LOOKUP) && r4.outbound;
    key     = swap ? {r4.dst_addr, r4.src_addr, r4.dst_port, r4.src_port, r4.proto}
                   : {r4.src_addr, r4.dst_addr, r4.src_port, r4.dst_port, r4.proto};

    slot_base = SLOT_W'(32'(addr4) * WAYS);

    for (int w = 0; w < WAYS; w++) begin
      vrow[w]  = row_cur[w*WAY_BITS + ENTRY_W];
      match[w] = vrow[w] && (row_cur[w*WAY_BITS +: ENTRY_W] == key);
    end

    // lowest matching and lowest free way
    hit      = |match;
    has_free = ~&vrow;
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
      if (!vrow[w]) free_way = WAY_W'(w);
    end
    hit_slot  = slot_base + SLOT_W'(hit_way);
    free_slot = slot_base + SLOT_W'(free_way);

    del_way = WAY_W'(32'(r4.del_handle) % WAYS);
    del_ok  = (32'(r4.del_handle) < SLOT_COUNT) && vrow[del_way];

    row_new = row_cur;
    ram_we  = 1'b0;
    status  = ST_NOT_FOUND;
    handle  = '0;

    case (r4.op)
      OP_LOOKUP: begin
        if (hit) begin
          status = ST_OK;
          handle = HANDLE_W'(hit_slot);
        end
      end
      OP_INSERT: begin
        if (has_free) begin
          status = ST_OK;
          handle = HANDLE_W'(free_slot);
          row_new[free_way*WAY_BITS +: WAY_BITS] = {1'b1, key};
          ram_we = fire;
        end else begin
          status = ST_FULL;
        end
      end
      OP_DELETE: begin
        handle = r4.del_handle;
        if (del_ok) begin
          status = ST_OK;
          row_new[del_way*WAY_BITS + ENTRY_W] = 1'b0;
          ram_we = fire;
        end else begin
          status = ST_BAD_HANDLE;
        end
      end
      default: begin
        status = ST_NOT_FOUND;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (en_out) begin
      m_tuser <= status;
      m_tdata <= 16'(handle);
    end
  end

`ifndef SYNTHESIS
  // an accepted insert writes its row back with the new slot in use
  assert property (@(posedge clk) disable iff (rst)
    (fire && r4.op == OP_INSERT && has_free)
      |-> (ram_we && row_new[free_way*WAY_BITS + ENTRY_W]))
    else $error("insert did not set slot valid");

  // a successful delete writes its row back with the slot free
  assert property (@(posedge clk) disable iff (rst)
    (fire && r4.op == OP_DELETE && del_ok)
      |-> (ram_we && !row_new[del_way*WAY_BITS + ENTRY_W]))
    else $error("delete did not clear slot valid");

  // a stalled compare-stage request is never dropped
  assert property (@(posedge clk) disable iff (rst)
    (v4 && !en_out) |=> (v4 && $stable(addr4)))
    else $error("stalled request lost in compare stage");

  // no request is taken while the rows are being cleared
  assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_tready)
    else $error("request accepted during clearing pass");

  // rows change only by a request leaving the compare stage or by the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    ram_wr |-> (fire || clr_busy))
    else $error("row written outside compare stage");
`endif

endmodule

`default_nettype wire

### tb/five_tuple_connection_table_top_tb.sv
`timescale 1ns / 1ps
// Testbench for five_tuple_connection_table_top: directed and random table requests
// checked against a flow table predictor kept in the bench. Depends on ftct_pkg and the RTL.
module five_tuple_connection_table_top_tb;
  import ftct_pkg::*;

  // opcode 3 has no package name; the block treats it as a no-op
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0]  proto;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
  } flow_t;

  typedef struct {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
  } reply_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [119:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [15:0]  m_tdata;
  logic [1:0]   m_tuser;

  five_tuple_connection_table_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // bench copy of the table; entry contents only read where the valid bit is set
  bit          tbl_valid [SLOT_COUNT];
  logic [63:0] tbl_addr  [SLOT_COUNT];   // {src_addr, dst_addr}
  logic [39:0] tbl_ppp   [SLOT_COUNT];   // {src_port, dst_port, proto}

  reply_t      reply_q[$];
  int          error_count   = 0;
  int          request_count = 0;
  int          status_seen[4];
  int          send_idle     = 0;
  int          recv_idle     = 0;
  int unsigned cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, reply_q.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned bucket_of_flow(flow_t f);
    logic [31:0] sum;
    sum = 32'(f.proto) + f.sa + f.da + 32'(f.sp) + 32'(f.dp);
    return sum % 32'(HASH_BUCKETS);
  endfunction

  function automatic flow_t reverse_flow(flow_t f);
    flow_t r;
    r = f;
    r.sa = f.da;
    r.da = f.sa;
    r.sp = f.dp;
    r.dp = f.sp;
    return r;
  endfunction

  function automatic flow_t stored_flow(int s);
    flow_t f;
    f.sa    = tbl_addr[s][63:32];
    f.da    = tbl_addr[s][31:0];
    f.sp    = tbl_ppp[s][39:24];
    f.dp    = tbl_ppp[s][23:8];
    f.proto = tbl_ppp[s][7:0];
    return f;
  endfunction

  // applies one request to the bench table and returns the reply it must produce
  function automatic reply_t conn_table_step(req_t r);
    reply_t      rep;
    flow_t       f;
    int unsigned base;
    int          s;
    int          w;
    bit          done;
    rep.status = ST_NOT_FOUND;
    rep.handle = '0;
    done       = 1'b0;
    f          = '{r.proto, r.src_addr, r.dst_addr, r.src_port, r.dst_port};
    case (r.op)
      OP_LOOKUP: begin
        if (r.outbound) f = reverse_flow(f);
        base = bucket_of_flow(f) * WAYS;
        // lowest matching way wins when tuples are duplicated
        for (w = 0; w < WAYS && !done; w++) begin
          s = base + w;
          if (tbl_valid[s] && tbl_addr[s] == {f.sa, f.da} &&
              tbl_ppp[s] == {f.sp, f.dp, f.proto}) begin
            rep.status = ST_OK;
            rep.handle = HANDLE_W'(s);
            done       = 1'b1;
          end
        end
      end
      OP_INSERT: begin
        rep.status = ST_FULL;
        base       = bucket_of_flow(f) * WAYS;
        for (w = 0; w < WAYS && !done; w++) begin
          s = base + w;
          if (!tbl_valid[s]) begin
            tbl_valid[s] = 1'b1;
            tbl_addr[s]  = {f.sa, f.da};
            tbl_ppp[s]   = {f.sp, f.dp, f.proto};
            rep.status   = ST_OK;
            rep.handle   = HANDLE_W'(s);
            done         = 1'b1;
          end
        end
      end
      OP_DELETE: begin
        rep.handle = r.del_handle;
        if (r.del_handle < SLOT_COUNT && tbl_valid[r.del_handle]) begin
          tbl_valid[r.del_handle] = 1'b0;
          rep.status              = ST_OK;
        end else begin
          rep.status = ST_BAD_HANDLE;
        end
      end
      default: ;  // unused opcode: not found, handle 0, table untouched
    endcase
    return rep;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic req_t make_request(op_t op, flow_t f, logic ob, logic [HANDLE_W-1:0] dh);
    req_t r;
    r.op         = op;
    r.proto      = f.proto;
    r.src_addr   = f.sa;
    r.dst_addr   = f.da;
    r.src_port   = f.sp;
    r.dst_port   = f.dp;
    r.outbound   = ob;
    r.del_handle = dh;
    return r;
  endfunction

  function automatic flow_t random_flow();
    flow_t f;
    f.proto = 8'($urandom_range(255));
    f.sa    = $urandom;
    f.da    = $urandom;
    f.sp    = 16'($urandom_range(65535));
    f.dp    = 16'($urandom_range(65535));
    return f;
  endfunction

  // different tuple, same hash sum: shift value between the addresses, maybe swap ports
  function automatic flow_t sibling_flow(flow_t f);
    flow_t       g;
    logic [31:0] d;
    g    = f;
    d    = $urandom;
    g.sa = f.sa + d;
    g.da = f.da - d;
    if ($urandom_range(1)) begin
      g.sp = f.dp;
      g.dp = f.sp;
    end
    return g;
  endfunction

  function automatic int pick_live_slot();
    int start;
    int i;
    int s;
    start = $urandom_range(SLOT_COUNT - 1);
    for (i = 0; i < SLOT_COUNT; i++) begin
      s = (start + i) % SLOT_COUNT;
      if (tbl_valid[s]) return s;
    end
    return -1;
  endfunction

  // mostly requests that hit live entries or crowd their buckets, the rest noise
  function automatic req_t random_request();
    flow_t               f;
    int                  live;
    int                  k;
    int                  j;
    logic                ob;
    logic [HANDLE_W-1:0] dh;
    f    = random_flow();
    live = pick_live_slot();
    k    = $urandom_range(99);
    j    = $urandom_range(99);
    ob   = 1'($urandom_range(1));
    dh   = HANDLE_W'($urandom_range(511));
    if (k < 38) begin
      if (live >= 0 && j < 35) f = sibling_flow(stored_flow(live));
      else if (live >= 0 && j < 60) f = stored_flow(live);
      return make_request(OP_INSERT, f, ob, dh);
    end
    if (k < 70) begin
      if (live >= 0 && j < 55) begin
        f = stored_flow(live);
        if (ob) f = reverse_flow(f);
      end else if (live >= 0 && j < 70) begin
        // stored orientation sent as outbound: swapped compare, normally a miss
        f  = stored_flow(live);
        ob = 1'b1;
      end else if (live >= 0 && j < 85) begin
        f = sibling_flow(stored_flow(live));
      end
      return make_request(OP_LOOKUP, f, ob, dh);
    end
    if (k < 94) begin
      if (live >= 0 && j < 65) dh = HANDLE_W'(live);
      return make_request(OP_DELETE, f, ob, dh);
    end
    return make_request(op_t'(OP_UNUSED), f, ob, dh);
  endfunction

  // drives one request at the falling edge and holds it until accepted
  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, r.del_handle, r.dst_port, r.src_port, r.dst_addr, r.src_addr, r.proto};
    s_tuser  <= {r.outbound, r.op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    reply_q.push_back(conn_table_step(r));
    request_count++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    reply_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          $error("reply with no request outstanding: status %0d handle %0d",
                 m_tuser, m_tdata[HANDLE_W-1:0]);
          error_count++;
        end else begin
          want = reply_q.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_tuser);
            error_count++;
          end
          if (m_tdata[HANDLE_W-1:0] !== want.handle) begin
            $error("handle: expected %0d, actual %0d", want.handle, m_tdata[HANDLE_W-1:0]);
            error_count++;
          end
          status_seen[want.status]++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // empty table: miss, deletes of free and out-of-range handles, unused opcode
  task automatic test_empty_table();
    send_request(make_request(OP_LOOKUP, random_flow(), 1'b0, 9'd0));
    send_request(make_request(OP_DELETE, random_flow(), 1'b0, 9'd0));
    send_request(make_request(OP_DELETE, random_flow(), 1'b1, 9'd399));
    send_request(make_request(OP_DELETE, random_flow(), 1'b0, 9'd400));
    send_request(make_request(OP_DELETE, random_flow(), 1'b1, 9'd511));
    send_request(make_request(op_t'(OP_UNUSED), '1, 1'b1, '1));
  endtask

  // all-zero and all-one tuples, plus an asymmetric flow looked up both ways
  task automatic test_extreme_tuples();
    flow_t web_f;
    web_f = '{8'd6, 32'h0a00_0001, 32'hc0a8_0001, 16'd1234, 16'd80};
    send_request(make_request(OP_INSERT, '0, 1'b0, '0));
    send_request(make_request(OP_INSERT, '1, 1'b1, '1));
    send_request(make_request(OP_LOOKUP, '1, 1'b0, '1));
    send_request(make_request(OP_LOOKUP, '1, 1'b1, '0));
    send_request(make_request(OP_INSERT, web_f, 1'b1, 9'h155));
    send_request(make_request(OP_LOOKUP, web_f, 1'b0, 9'h0aa));
    send_request(make_request(OP_LOOKUP, reverse_flow(web_f), 1'b1, '0));
    send_request(make_request(OP_LOOKUP, web_f, 1'b1, '0));
  endtask

  // duplicates fill bucket 0, then full, lowest-way hit, delete and refill
  task automatic test_full_bucket();
    repeat (3) send_request(make_request(OP_INSERT, '0, 1'b0, '0));
    send_request(make_request(OP_INSERT, '0, 1'b1, '1));
    send_request(make_request(OP_LOOKUP, '0, 1'b0, '0));
    send_request(make_request(OP_DELETE, '0, 1'b0, 9'd0));
    send_request(make_request(OP_DELETE, '0, 1'b0, 9'd0));
    send_request(make_request(OP_LOOKUP, '0, 1'b1, '0));
    send_request(make_request(OP_INSERT, '0, 1'b0, '0));
  endtask

  task automatic test_random_traffic(int count, int s_idle, int r_idle);
    req_t r;
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (count) begin
      r = random_request();
      send_request(r);
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle = 29;
    recv_idle = 88;
    test_empty_table();
    test_extreme_tuples();
    test_full_bucket();
    test_random_traffic(430, 29, 88);
    test_random_traffic(430, 88, 29);
    test_random_traffic(430, 0, 0);
    s_tvalid <= 1'b0;

    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests over three back-pressure phases, %0d mismatches",
             request_count, error_count);
    $display("replies seen: ok %0d, not found %0d, bucket full %0d, unused handle %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
